>>> rtl/dsc_pkg.sv
// dsc_pkg: shared widths, limits, state and handshake types of the
// divisible subarray counter; no dependencies

package dsc_pkg;

    localparam int VALUE_W         = 31;
    localparam int MOD_W           = 11;
    localparam int COUNT_W         = 31;
    localparam int BUCKET_W        = 17;
    localparam int DIV_W           = 32;
    localparam int DIV_STEP        = 4;
    localparam int DEF_MAX_BUCKETS = 1024;

    localparam logic [BUCKET_W-1:0] BUCKET_LIMIT = {BUCKET_W{1'b1}};
    localparam logic [COUNT_W-1:0]  ANSWER_LIMIT = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic start;
        logic neg;
    } t_mod_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_rsp;

endpackage

>>> rtl/dsc_ram.sv
// dsc_ram: generic single write port, single read port ram with
// registered read data; no dependencies

module dsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/dsc_mod_unit.sv
// dsc_mod_unit: iterative remainder unit, DIV_STEP quotient bits per cycle,
// floor modulo of a sign and magnitude operand; depends on dsc_pkg

module dsc_mod_unit
    import dsc_pkg::*;
#(
    parameter int MW = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mod_req         i_req,
    input  logic [DIV_W-1:0] i_mag,
    input  logic [MW-1:0]    i_mod,
    output t_mod_rsp         o_rsp,
    output logic [MW-1:0]    o_rem
);

    localparam int ITERS = DIV_W / DIV_STEP;
    localparam int CNT_W = (ITERS > 1) ? $clog2(ITERS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITERS - 1);

    logic             r_busy;
    logic             r_fix;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_mag;
    logic [MW-1:0]    r_rem;
    logic             r_neg;
    logic [MW-1:0]    r_m;
    logic [MW-1:0]    r_res;

    logic [DIV_W-1:0] n_mag;
    logic [MW-1:0]    n_rem;
    logic [MW-1:0]    n_res;
    logic [MW:0]      s_t;

    // DIV_STEP restoring steps per cycle
    always_comb begin
        n_mag = r_mag;
        n_rem = r_rem;
        s_t   = '0;
        for (int k = 0; k < DIV_STEP; k++) begin
            s_t   = {n_rem, n_mag[DIV_W-1]};
            n_mag = {n_mag[DIV_W-2:0], 1'b0};
            if (s_t >= {1'b0, r_m}) begin
                n_rem = MW'(s_t - {1'b0, r_m});
            end else begin
                n_rem = MW'(s_t);
            end
        end
    end

    // negative operand maps to the nonnegative residue
    always_comb begin
        if (r_neg && (r_rem != '0)) begin
            n_res = r_m - r_rem;
        end else begin
            n_res = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_fix  <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mag <= i_mag;
            r_rem <= '0;
            r_neg <= i_req.neg;
            r_m   <= i_mod;
        end else if (r_busy) begin
            r_mag <= n_mag;
            r_rem <= n_rem;
        end
        if (r_fix) begin
            r_res <= n_res;
        end
    end

    assign o_rsp.busy = r_busy | r_fix;
    assign o_rsp.done = r_done;
    assign o_rem      = r_res;

    a_res_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_res < r_m))
        else $error("residue not below modulus");

    a_done_after_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_fix))
        else $error("done without final correction");

endmodule

>>> rtl/divisible_subarray_counter.sv
// divisible_subarray_counter: top level, sequencer, residue histogram and
// answer accumulation; depends on dsc_pkg, dsc_ram, dsc_mod_unit
//
// usage
// input channel i_in_valid / o_in_ready carries one word per element:
// i_value (signed) and i_last_item. output channel o_out_valid /
// i_out_ready carries one word per sequence, after the element marked
// last: o_pair_count and o_saturated. the modulus register is written over
// i_cfg_valid / o_cfg_ready (always ready); the user must write it only while
// no element is in flight, the block itself does not enforce this.
// o_in_ready stays low from acceptance of an element until its update is
// done, so a new element is taken only once the one before is through:
// the prefix sum is reduced by the remainder unit at 4 bits per cycle over
// 32 bits plus 1 correction step, then one histogram read and one
// read-modify-write on the single ram port pair. o_out_valid is registered
// at the update of the last element. after reset and after every last element
// the histogram is cleared (bucket 0 set to one) one bucket per cycle, with o_in_ready low.
// the result word sits in an output register; a stalled receiver only
// holds back the next last element, not the clearing or ordinary elements.

module divisible_subarray_counter
    import dsc_pkg::*;
#(
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [MOD_W-1:0]   i_cfg_modulus,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_last_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [COUNT_W-1:0] o_pair_count,
    output logic               o_saturated
);

    localparam int AW = $clog2(MAX_BUCKETS);
    localparam int MW = $clog2(MAX_BUCKETS) + 1;
    localparam int CW = (MW > MOD_W) ? MW : MOD_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BUCKETS - 1);

    t_state r_state;
    t_state n_state;

    logic [MOD_W-1:0]   r_modulus;
    logic [AW-1:0]      r_clr_addr;
    logic [AW-1:0]      r_prefix;
    logic [COUNT_W-1:0] r_answer;
    logic               r_overflow;
    logic               r_last;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_sat;

    logic [CW-1:0]      s_mod_x;
    logic [MW-1:0]      s_mod_eff;
    logic [DIV_W-1:0]   s_sum;
    logic [DIV_W-1:0]   s_mag;
    logic               in_acc;
    logic               upd_go;

    t_mod_req           mod_req;
    t_mod_rsp           mod_rsp;
    logic [MW-1:0]      mod_rem;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [BUCKET_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [BUCKET_W-1:0] ram_rdata;

    logic [COUNT_W:0]   s_ans_sum;
    logic [COUNT_W-1:0] n_answer;
    logic               n_overflow;
    logic               s_bucket_full;

    // effective modulus: zero acts as one, large values clamp
    always_comb begin
        s_mod_x = CW'(r_modulus);
        if (s_mod_x == '0) begin
            s_mod_eff = MW'(1);
        end else if (s_mod_x > CW'(MAX_BUCKETS)) begin
            s_mod_eff = MW'(MAX_BUCKETS);
        end else begin
            s_mod_eff = MW'(s_mod_x);
        end
    end

    // held residue plus new value, as sign and magnitude
    assign s_sum = {i_value[VALUE_W-1], i_value} + DIV_W'(r_prefix);
    assign s_mag = s_sum[DIV_W-1] ? (~s_sum + 1'b1) : s_sum;

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = (r_state == ST_IDLE);
    assign in_acc        = i_in_valid && o_in_ready;
    assign mod_req.start = in_acc;
    assign mod_req.neg   = s_sum[DIV_W-1];

    dsc_mod_unit #(
        .MW (MW)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .i_mag   (s_mag),
        .i_mod   (s_mod_eff),
        .o_rsp   (mod_rsp),
        .o_rem   (mod_rem)
    );

    dsc_ram #(
        .WIDTH (BUCKET_W),
        .DEPTH (MAX_BUCKETS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // answer and bucket update with saturation
    assign s_ans_sum     = {1'b0, r_answer} + (COUNT_W + 1)'(ram_rdata);
    assign s_bucket_full = (ram_rdata >= BUCKET_LIMIT);
    always_comb begin
        n_overflow = r_overflow | s_bucket_full;
        if (s_ans_sum > {1'b0, ANSWER_LIMIT}) begin
            n_answer   = ANSWER_LIMIT;
            n_overflow = 1'b1;
        end else begin
            n_answer = COUNT_W'(s_ans_sum);
        end
    end

    assign upd_go = !r_last || !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (mod_rsp.done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (upd_go) begin
                    n_state = r_last ? ST_CLEAR : ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // ram controls
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_prefix;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = AW'(mod_rem);
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = (r_clr_addr == '0) ? BUCKET_W'(1) : '0;
            end
            ST_DIV: begin
                ram_re = mod_rsp.done;
            end
            ST_UPDATE: begin
                ram_we    = upd_go;
                ram_wdata = s_bucket_full ? BUCKET_LIMIT : (ram_rdata + 1'b1);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_modulus   <= MOD_W'(1);
            r_clr_addr  <= '0;
            r_prefix    <= '0;
            r_answer    <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_modulus <= i_cfg_modulus;
            end
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == ST_DIV && mod_rsp.done) begin
                r_prefix <= AW'(mod_rem);
            end
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_UPDATE && upd_go) begin
                if (r_last) begin
                    r_out_valid <= 1'b1;
                    r_clr_addr  <= '0;
                    r_prefix    <= '0;
                    r_answer    <= '0;
                    r_overflow  <= 1'b0;
                end else begin
                    r_answer   <= n_answer;
                    r_overflow <= n_overflow;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_last <= i_last_item;
        end
        if (r_state == ST_UPDATE && upd_go && r_last) begin
            r_out_count <= n_answer;
            r_out_sat   <= n_overflow;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pair_count = r_out_count;
    assign o_saturated  = r_out_sat;

    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && $past(r_state) == ST_CLEAR && $past(i_rst_n))
            |-> (r_clr_addr == $past(r_clr_addr) + 1'b1))
        else $error("clear sweep skipped a bucket");

    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_UPDATE))
        else $error("result word raised outside update");

    a_idle_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !mod_rsp.busy)
        else $error("remainder unit busy while idle");

endmodule

>>> dv/tb.sv
// tb: self-checking bench for divisible_subarray_counter; an internal predictor
// tracks prefix residues and the residue histogram per sequence
// depends on rtl/dsc_pkg.sv and rtl/divisible_subarray_counter.sv

module tb
    import dsc_pkg::*;
();

    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int DRAIN_WAIT  = 24;
    localparam int END_WAIT    = 1100;

    typedef struct {
        logic [COUNT_W-1:0] pair_count;
        logic               saturated;
    } t_count_word;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    logic [MOD_W-1:0]   i_cfg_modulus = '0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic [VALUE_W-1:0] i_value       = '0;
    logic               i_last_item   = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    logic [COUNT_W-1:0] o_pair_count;
    logic               o_saturated;

    t_count_word pending_counts[$];
    t_count_word got_word;
    int          err_cnt         = 0;
    int          cycle_cnt       = 0;
    int          sender_idle_pct = 0;
    int          recv_stall_pct  = 0;
    int          hold_cycles     = 0;

    logic [MOD_W-1:0] modulus_shadow = MOD_W'(1);
    longint           residue_acc;
    longint           answer_acc;
    longint           bucket_cnt[DEF_MAX_BUCKETS];
    logic             overflow_flag;

    divisible_subarray_counter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_modulus (i_cfg_modulus),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_value       (i_value),
        .i_last_item   (i_last_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pair_count  (o_pair_count),
        .o_saturated   (o_saturated)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_counts.size() == 0) begin
                $error("unexpected word: pair_count %0d saturated %0d",
                       o_pair_count, o_saturated);
                err_cnt++;
            end else begin
                got_word = pending_counts.pop_front();
                if (o_pair_count !== got_word.pair_count) begin
                    $error("pair_count: expected %0d, got %0d",
                           got_word.pair_count, o_pair_count);
                    err_cnt++;
                end
                if (o_saturated !== got_word.saturated) begin
                    $error("saturated: expected %0d, got %0d",
                           got_word.saturated, o_saturated);
                    err_cnt++;
                end
            end
        end
    end

    function automatic void clear_tally();
        foreach (bucket_cnt[i]) bucket_cnt[i] = 0;
        bucket_cnt[0] = 1;
        residue_acc   = 0;
        answer_acc    = 0;
        overflow_flag = 1'b0;
    endfunction

    function automatic void tally_element(logic [VALUE_W-1:0] val, logic last);
        longint      v;
        longint      m;
        longint      vm;
        longint      idx;
        longint      old;
        longint      sum;
        t_count_word w;
        v = longint'($signed(val));
        if (modulus_shadow == '0) begin
            m = 1;
        end else if (modulus_shadow > MOD_W'(DEF_MAX_BUCKETS)) begin
            m = DEF_MAX_BUCKETS;
        end else begin
            m = longint'(modulus_shadow);
        end
        vm = v % m;
        if (vm < 0) vm += m;
        idx = (residue_acc + vm) % m;
        residue_acc = idx;
        old = bucket_cnt[idx];
        sum = answer_acc + old;
        if (sum > longint'(ANSWER_LIMIT)) begin
            sum = longint'(ANSWER_LIMIT);
            overflow_flag = 1'b1;
        end
        answer_acc = sum;
        if (old >= longint'(BUCKET_LIMIT)) begin
            bucket_cnt[idx] = longint'(BUCKET_LIMIT);
            overflow_flag = 1'b1;
        end else begin
            bucket_cnt[idx] = old + 1;
        end
        if (last) begin
            w.pair_count = answer_acc[COUNT_W-1:0];
            w.saturated  = overflow_flag;
            pending_counts.insert(pending_counts.size(), w);
            clear_tally();
        end
    endfunction

    function automatic int pick_value();
        int r;
        int v;
        r = $urandom_range(9);
        if (r < 5) begin
            v = int'($urandom_range(40)) - 20;
        end else if (r < 7) begin
            v = int'($urandom_range(2000000000)) - 1000000000;
        end else if (r < 9) begin
            v = $urandom();
        end else begin
            v = (int'($urandom_range(20)) - 10) * int'(modulus_shadow);
        end
        return v;
    endfunction

    function automatic int pick_modulus();
        int r;
        r = $urandom_range(9);
        case (r)
            0: return 0;
            1: return 1;
            2: return DEF_MAX_BUCKETS;
            3: return int'($urandom_range(2047, DEF_MAX_BUCKETS + 1));
            4, 5, 6: return int'($urandom_range(16, 2));
            default: return int'($urandom_range(DEF_MAX_BUCKETS, 1));
        endcase
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(12, 1);
        if (r < 95) return $urandom_range(60, 13);
        return $urandom_range(250, 61);
    endfunction

    task automatic send_element(int val, logic last);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_value     <= val[VALUE_W-1:0];
        i_last_item <= last;
        do @(posedge i_clk); while (!o_in_ready);
        tally_element(val[VALUE_W-1:0], last);
    endtask

    task automatic wait_for_counts();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_counts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_modulus(int m);
        wait_for_counts();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid   <= 1'b1;
        i_cfg_modulus <= MOD_W'(m);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        modulus_shadow = MOD_W'(m);
    endtask

    task automatic test_reset_modulus();
        send_element(5, 1'b0);
        send_element(-3, 1'b0);
        send_element(7, 1'b1);
        send_element(-1, 1'b1);
        wait_for_counts();
    endtask

    task automatic test_modulus_extremes();
        write_modulus(0);
        send_element(4, 1'b0);
        send_element(-9, 1'b1);
        write_modulus(2047);
        send_element(1024, 1'b0);
        send_element(-1024, 1'b0);
        send_element(2048, 1'b0);
        send_element(3, 1'b1);
        write_modulus(DEF_MAX_BUCKETS);
        send_element(1023, 1'b0);
        send_element(1, 1'b0);
        send_element(-2048, 1'b1);
        write_modulus(DEF_MAX_BUCKETS + 1);
        send_element(1024, 1'b0);
        send_element(-1, 1'b1);
        wait_for_counts();
    endtask

    task automatic test_value_extremes();
        write_modulus(7);
        send_element(-1000000000, 1'b0);
        send_element(1000000000, 1'b0);
        send_element(-(1 << 30), 1'b0);
        send_element((1 << 30) - 1, 1'b0);
        send_element(0, 1'b1);
        wait_for_counts();
    endtask

    task automatic test_modulus_change_mid_sequence();
        write_modulus(DEF_MAX_BUCKETS);
        send_element(1000, 1'b0);
        send_element(20, 1'b0);
        write_modulus(5);
        send_element(-3, 1'b0);
        send_element(2, 1'b1);
        wait_for_counts();
    endtask

    task automatic test_output_backpressure();
        int s;
        write_modulus(3);
        hold_cycles = 4000;
        for (s = 0; s < 4; s++) begin
            send_element(pick_value(), 1'b0);
            send_element(pick_value(), 1'b0);
            send_element(pick_value(), 1'b1);
        end
        wait_for_counts();
    endtask

    task automatic run_random_phase(int send_pct, int recv_pct, int n_items);
        int sent;
        int len;
        int k;
        sender_idle_pct = send_pct;
        recv_stall_pct  = recv_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(3) == 0) write_modulus(pick_modulus());
            len = pick_length();
            for (k = 1; k <= len; k++) begin
                if (k > 1 && $urandom_range(39) == 0) write_modulus(pick_modulus());
                send_element(pick_value(), k == len);
                sent++;
            end
        end
        wait_for_counts();
    endtask

    task automatic test_random();
        run_random_phase(0, 0, 350);
        run_random_phase(85, 0, 350);
        run_random_phase(0, 85, 350);
        run_random_phase(20, 20, 350);
    endtask

    initial begin
        clear_tally();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_modulus();
        test_modulus_extremes();
        test_value_extremes();
        test_modulus_change_mid_sequence();
        test_output_backpressure();
        test_random();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        repeat (END_WAIT) @(posedge i_clk);
        if (err_cnt == 0 && pending_counts.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
